FILE: src/spim0_pkg.sv
// shared types and constants for the spi mode-0 byte master
package spim0_pkg;

  localparam int unsigned ByteBits = 8;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_START = 2'd1,
    MODE_STOP  = 2'd2,
    MODE_SWAP  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    CFG_SPEED      = 2'd0,
    CFG_BUS_COUNT  = 2'd1,
    CFG_ACTIVE_BUS = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SPEED_500K = 2'd0,
    SPEED_1M   = 2'd1,
    SPEED_5M   = 2'd2
  } speed_e;

  typedef enum logic [1:0] {
    PH_DRIVE  = 2'd0,
    PH_RISE   = 2'd1,
    PH_SAMPLE = 2'd2,
    PH_FALL   = 2'd3
  } phase_e;

  typedef struct packed {
    logic [3:0]          select_lines;
    logic                clock_level;
    logic                mosi_level;
    logic                busy_res;
    logic                received_valid;
    logic [ByteBits-1:0] received_byte;
  } result_t;

endpackage

FILE: src/spi_mode0_byte_master.sv
// spi mode-0 byte master: tick and command items in, pin state results out
// a result appears in the output register in the cycle after its item is accepted
// throughput: one item per cycle unless out_ready_i holds a full result register; the
// state update and pin decode sit between the input handshake and a single result register
// input is accepted while the result register is empty or being drained
// reset: no select asserted, sck and mosi low, no exchange, result register empty
module spi_mode0_byte_master #(
  parameter int unsigned NUM_BUSES = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_index_i,
  input  logic [2:0]                  cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  mode_i,
  input  logic [spim0_pkg::ByteBits-1:0] send_byte_i,
  input  logic                        miso_level_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [3:0]                  select_lines_o,
  output logic                        clock_level_o,
  output logic                        mosi_level_o,
  output logic                        busy_res_o,
  output logic                        received_valid_o,
  output logic [spim0_pkg::ByteBits-1:0] received_byte_o
);
  import spim0_pkg::*;

  localparam logic [2:0] BitLast = 3'(ByteBits - 1);

  logic [1:0] speed_q;
  logic [2:0] bus_count_q;
  logic [1:0] active_bus_q;

  logic [ByteBits-1:0] tx_q, tx_d;
  logic [ByteBits-1:0] rx_q, rx_d;
  logic [2:0]          bit_q, bit_d;
  phase_e              phase_q, phase_d;
  logic [2:0]          tick_q, tick_d;
  logic                active_q, active_d;
  logic                sel_q, sel_d;
  logic                sck_q, sck_d;
  logic                mosi_q, mosi_d;

  logic    out_valid_q;
  result_t res_q, res_d;

  logic       accept;
  logic       usable;
  logic [2:0] seg_len;
  logic [2:0] tick_inc;
  mode_e      mode;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign mode       = mode_e'(mode_i);

  assign usable = ({1'b0, active_bus_q} < bus_count_q) && (32'(active_bus_q) < NUM_BUSES);

  always_comb begin
    case (speed_e'(speed_q))
      SPEED_5M: seg_len = 3'd1;
      SPEED_1M: seg_len = 3'd2;
      default:  seg_len = 3'd4;
    endcase
  end

  assign tick_inc = tick_q + 3'd1;

  always_comb begin
    tx_d     = tx_q;
    rx_d     = rx_q;
    bit_d    = bit_q;
    phase_d  = phase_q;
    tick_d   = tick_q;
    active_d = active_q;
    sel_d    = sel_q;
    sck_d    = sck_q;
    mosi_d   = mosi_q;
    res_d    = '0;
    if (active_q) begin
      if (mode == MODE_TICK) begin
        tick_d = tick_inc;
        if (tick_inc >= seg_len) begin
          tick_d = '0;
          case (phase_q)
            PH_DRIVE: begin
              sck_d   = 1'b1;
              phase_d = PH_RISE;
            end
            PH_RISE: begin
              if (usable && miso_level_i) begin
                rx_d[BitLast - bit_q] = 1'b1;
              end
              phase_d = PH_SAMPLE;
            end
            PH_SAMPLE: begin
              sck_d   = 1'b0;
              phase_d = PH_FALL;
            end
            default: begin
              phase_d = PH_DRIVE;
              if (bit_q >= BitLast) begin
                active_d             = 1'b0;
                bit_d                = '0;
                res_d.received_valid = 1'b1;
                res_d.received_byte  = rx_q;
              end else begin
                bit_d  = bit_q + 3'd1;
                tx_d   = {tx_q[ByteBits-2:0], 1'b0};
                mosi_d = tx_q[ByteBits-2];
              end
            end
          endcase
        end
      end
    end else begin
      case (mode)
        MODE_START: if (usable) sel_d = 1'b1;
        MODE_STOP:  if (usable) sel_d = 1'b0;
        MODE_SWAP: begin
          tx_d     = send_byte_i;
          rx_d     = '0;
          bit_d    = '0;
          phase_d  = PH_DRIVE;
          tick_d   = '0;
          active_d = 1'b1;
          mosi_d   = send_byte_i[ByteBits-1];
        end
        default: ;
      endcase
    end
    res_d.select_lines = 4'hF;
    if (usable && sel_d) begin
      res_d.select_lines[active_bus_q] = 1'b0;
    end
    res_d.clock_level = usable && sck_d;
    res_d.mosi_level  = usable && mosi_d;
    res_d.busy_res    = active_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q      <= '0;
      bus_count_q  <= '0;
      active_bus_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_SPEED:      speed_q      <= cfg_data_i[1:0];
        CFG_BUS_COUNT:  bus_count_q  <= cfg_data_i;
        CFG_ACTIVE_BUS: active_bus_q <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_q     <= '0;
      rx_q     <= '0;
      bit_q    <= '0;
      phase_q  <= PH_DRIVE;
      tick_q   <= '0;
      active_q <= 1'b0;
      sel_q    <= 1'b0;
      sck_q    <= 1'b0;
      mosi_q   <= 1'b0;
    end else if (accept) begin
      tx_q     <= tx_d;
      rx_q     <= rx_d;
      bit_q    <= bit_d;
      phase_q  <= phase_d;
      tick_q   <= tick_d;
      active_q <= active_d;
      sel_q    <= sel_d;
      sck_q    <= sck_d;
      mosi_q   <= mosi_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign select_lines_o   = res_q.select_lines;
  assign clock_level_o    = res_q.clock_level;
  assign mosi_level_o     = res_q.mosi_level;
  assign busy_res_o       = res_q.busy_res;
  assign received_valid_o = res_q.received_valid;
  assign received_byte_o  = res_q.received_byte;

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> (phase_q == PH_DRIVE && tick_q == 3'd0 && bit_q == 3'd0))
    else $error("idle with exchange state left over");

  a_tick_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_q[2] == 1'b0)
    else $error("tick counter beyond longest segment");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.received_valid |-> !res_q.busy_res)
    else $error("received byte flagged during exchange");

  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_q.received_valid |-> res_q.received_byte == '0)
    else $error("received byte nonzero without valid");

  a_finish_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && active_q && !active_d |=> out_valid_q && res_q.received_valid)
    else $error("exchange ended without a received transfer");

endmodule
